FILE: rtl/ihf_pkg.sv
`default_nettype none

package ihf_pkg;

    localparam int IHF_MAX_FIELD = 32;

    localparam int MAG_W   = 32;
    localparam int CHAR_W  = 8;
    localparam int FLEN_W  = 6;
    localparam int SIZE_W  = 6;
    localparam int LEN_W   = 7;
    localparam int DIG_W   = 4;
    localparam int DIG_N   = 10;

    localparam logic [MAG_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic             neg;
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] nspc;
        logic [LEN_W-1:0] dstart;
    } ihf_layout_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIG_W'(10))
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ihf_req_if.sv
`default_nettype none

interface ihf_req_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [ihf_pkg::MAG_W-1:0]   value;
    logic [ihf_pkg::SIZE_W-1:0]  width;
    logic                        has_precision;
    logic [ihf_pkg::SIZE_W-1:0]  precision;

    modport source (output valid, kind, value, width, has_precision, precision,
                    input ready);
    modport sink (input valid, kind, value, width, has_precision, precision,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/ihf_chr_if.sv
`default_nettype none

interface ihf_chr_if;
    logic                        valid;
    logic                        ready;
    logic [ihf_pkg::CHAR_W-1:0]  out_char;
    logic                        last;
    logic [ihf_pkg::FLEN_W-1:0]  field_length;

    modport source (output valid, out_char, last, field_length, input ready);
    modport sink (input valid, out_char, last, field_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/ihf_div_unit.sv
`default_nettype none

// Divides the held magnitude by the base: for decimal the reciprocal product is
// registered first, then the quotient and remainder are formed; hex uses a shift.
module ihf_div_unit
(
    input  wire logic                        clk,
    input  wire logic                        load,
    input  wire logic [ihf_pkg::MAG_W-1:0]   load_mag,
    input  wire logic                        is_hex,
    input  wire logic                        mul_en,
    input  wire logic                        dig_en,
    output logic      [ihf_pkg::DIG_W-1:0]   digit,
    output logic                             q_zero
);

    logic [ihf_pkg::MAG_W-1:0]     mag_reg;
    logic [2*ihf_pkg::MAG_W-1:0]   prod_reg;
    logic [ihf_pkg::MAG_W-1:0]     quot;
    logic [ihf_pkg::MAG_W-1:0]     rem_full;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mag_reg <= load_mag;
        end
        else if (dig_en)
        begin
            mag_reg <= quot;
        end
        if (mul_en)
        begin
            prod_reg <= (2*ihf_pkg::MAG_W)'(mag_reg) * (2*ihf_pkg::MAG_W)'(ihf_pkg::RECIP_10);
        end
    end

    always_comb
    begin
        if (is_hex)
        begin
            quot = mag_reg >> ihf_pkg::DIG_W;
        end
        else
        begin
            quot = ihf_pkg::MAG_W'(prod_reg >> ihf_pkg::RECIP_SHIFT);
        end
        rem_full = mag_reg - ((quot << 3) + (quot << 1));
        digit    = is_hex ? mag_reg[ihf_pkg::DIG_W-1:0] : rem_full[ihf_pkg::DIG_W-1:0];
        q_zero   = (quot == '0);
    end

endmodule

`default_nettype wire

FILE: rtl/ihf_char_sel.sv
`default_nettype none

// Picks the character at a field position: spaces, then the sign, then
// zero padding, then the digits from most significant down.
module ihf_char_sel
(
    input  wire ihf_pkg::ihf_layout_t          layout,
    input  wire logic [ihf_pkg::LEN_W-1:0]     pos,
    output logic      [ihf_pkg::DIG_W-1:0]     dig_idx,
    input  wire logic [ihf_pkg::DIG_W-1:0]     dig_val,
    output logic      [ihf_pkg::CHAR_W-1:0]    out_char
);

    logic [ihf_pkg::LEN_W-1:0] rev_pos;

    always_comb
    begin
        rev_pos = layout.n - ihf_pkg::LEN_W'(1) - pos;
        dig_idx = rev_pos[ihf_pkg::DIG_W-1:0];
        if (pos < layout.nspc)
        begin
            out_char = ihf_pkg::CHAR_SPACE;
        end
        else if (layout.neg && (pos == layout.nspc))
        begin
            out_char = ihf_pkg::CHAR_MINUS;
        end
        else if (pos < layout.dstart)
        begin
            out_char = ihf_pkg::CHAR_ZERO;
        end
        else
        begin
            out_char = ihf_pkg::hex_char(dig_val);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/int_hex_field_formatter.sv
`default_nettype none

// Formats one 32-bit integer as a printf-style %d or %x field and sends it out
// one character per transfer, most significant first, with last set on the
// final character and the field length on every character. An item is accepted,
// then each digit is formed in the divide-by-base unit by its multiply and digit
// states (up to ten digits for decimal, eight for hex), the field is laid out,
// and then one character is loaded per cycle while the output is taken. The
// block takes no new request until the last character of the current one has
// entered the output register.
module int_hex_field_formatter
#(
    parameter int MAX_FIELD = ihf_pkg::IHF_MAX_FIELD
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ihf_req_if.sink    req,
    ihf_chr_if.source  chr
);

    typedef enum logic [4:0]
    {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIG  = 5'b00100,
        ST_CALC = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    localparam int LW = ihf_pkg::LEN_W;

    state_t                            state_reg, state_next;
    logic                              is_hex_reg;
    logic                              neg_reg;
    logic [LW-1:0]                     width_reg;
    logic [LW-1:0]                     prec_reg;
    logic [ihf_pkg::DIG_W-1:0]         ndig_reg;
    logic [LW-1:0]                     pos_reg;
    ihf_pkg::ihf_layout_t              layout_reg, layout_next;
    logic [ihf_pkg::DIG_W-1:0]         dig_mem [ihf_pkg::DIG_N];

    logic                              out_valid_reg;
    logic [ihf_pkg::CHAR_W-1:0]        out_char_reg;
    logic                              out_last_reg;
    logic [ihf_pkg::FLEN_W-1:0]        out_len_reg;

    logic                              accept;
    logic                              neg_in;
    logic [ihf_pkg::MAG_W-1:0]         mag_in;
    logic [LW-1:0]                     width_in, prec_in;
    logic [ihf_pkg::DIG_W-1:0]         digit;
    logic                              q_zero;
    logic [ihf_pkg::DIG_W-1:0]         dig_idx;
    logic [ihf_pkg::DIG_W-1:0]         dig_val;
    logic [ihf_pkg::CHAR_W-1:0]        sel_char;
    logic                              out_free;
    logic                              emit_load;
    logic                              emit_last;
    logic [LW-1:0]                     core_z, core;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign neg_in    = !req.kind && req.value[ihf_pkg::MAG_W-1];
    assign mag_in    = neg_in ? (ihf_pkg::MAG_W'(0) - req.value) : req.value;
    assign width_in  = ({1'b0, req.width} > LW'(MAX_FIELD)) ? LW'(MAX_FIELD)
                                                            : {1'b0, req.width};
    assign prec_in   = !req.has_precision ? '0
                     : (({1'b0, req.precision} > LW'(MAX_FIELD)) ? LW'(MAX_FIELD)
                                                                 : {1'b0, req.precision});

    assign out_free  = !out_valid_reg || chr.ready;
    assign emit_load = (state_reg == ST_EMIT) && out_free;
    assign emit_last = (pos_reg == layout_reg.n - LW'(1));

    ihf_div_unit u_div
    (
        .clk      (clk),
        .load     (accept),
        .load_mag (mag_in),
        .is_hex   (is_hex_reg),
        .mul_en   (state_reg == ST_MUL),
        .dig_en   (state_reg == ST_DIG),
        .digit    (digit),
        .q_zero   (q_zero)
    );

    ihf_char_sel u_sel
    (
        .layout   (layout_reg),
        .pos      (pos_reg),
        .dig_idx  (dig_idx),
        .dig_val  (dig_val),
        .out_char (sel_char)
    );

    assign dig_val = (dig_idx < ihf_pkg::DIG_W'(ihf_pkg::DIG_N)) ? dig_mem[dig_idx] : '0;

    always_comb
    begin
        core_z             = (LW'(ndig_reg) > prec_reg) ? LW'(ndig_reg) : prec_reg;
        core               = core_z + LW'(neg_reg);
        layout_next.neg    = neg_reg;
        layout_next.n      = (width_reg > core) ? width_reg : core;
        layout_next.nspc   = layout_next.n - core;
        layout_next.dstart = layout_next.n - LW'(ndig_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIG;
            end
            ST_DIG:
            begin
                state_next = q_zero ? ST_CALC : ST_MUL;
            end
            ST_CALC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ndig_reg      <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ndig_reg <= '0;
            end
            else if (state_reg == ST_DIG)
            begin
                ndig_reg <= ndig_reg + ihf_pkg::DIG_W'(1);
            end
            if (state_reg == ST_CALC)
            begin
                pos_reg <= '0;
            end
            else if (emit_load)
            begin
                pos_reg <= pos_reg + LW'(1);
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chr.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_hex_reg <= req.kind;
            neg_reg    <= neg_in;
            width_reg  <= width_in;
            prec_reg   <= prec_in;
        end
        if (state_reg == ST_DIG)
        begin
            dig_mem[ndig_reg] <= digit;
        end
        if (state_reg == ST_CALC)
        begin
            layout_reg <= layout_next;
        end
        if (emit_load)
        begin
            out_char_reg <= sel_char;
            out_last_reg <= emit_last;
            out_len_reg  <= ihf_pkg::FLEN_W'(layout_reg.n);
        end
    end

    assign chr.valid        = out_valid_reg;
    assign chr.out_char     = out_char_reg;
    assign chr.last         = out_last_reg;
    assign chr.field_length = out_len_reg;

    a_ndig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ndig_reg <= ihf_pkg::DIG_W'(ihf_pkg::DIG_N))
        else $error("digit count exceeds the digit store");

    a_calc_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (ndig_reg != '0))
        else $error("layout started with no digits");

    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIG) && q_zero) |=> (state_reg == ST_CALC))
        else $error("conversion did not end on a zero quotient");

    a_emit_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg < layout_reg.n))
        else $error("character position beyond the field");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !chr.ready) |-> !emit_load)
        else $error("output register overwritten before its transfer");

endmodule

`default_nettype wire

FILE: dv/ihf_tb_pkg.sv
`timescale 1ns / 1ps

package ihf_tb_pkg;

    typedef enum logic
    {
        KIND_DEC = 1'b0,
        KIND_HEX = 1'b1
    } fmt_kind_t;

    typedef struct packed {
        fmt_kind_t                   kind;
        logic [ihf_pkg::MAG_W-1:0]   value;
        logic [ihf_pkg::SIZE_W-1:0]  width;
        logic                        has_precision;
        logic [ihf_pkg::SIZE_W-1:0]  precision;
    } fmt_request_t;

endpackage

FILE: dv/ihf_field_checker.sv
`timescale 1ns / 1ps

module ihf_field_checker
(
    input  logic  clk,
    input  logic  rst_n,
    ihf_req_if    req,
    ihf_chr_if    chr,
    output int    fail_count,
    output int    pending,
    output int    chars_checked,
    output int    requests_seen
);

    import ihf_pkg::*;
    import ihf_tb_pkg::*;

    localparam int FIELD_MAX = IHF_MAX_FIELD;
    localparam int BUF_LEN   = FIELD_MAX + 2;

    typedef struct {
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [FLEN_W-1:0]  len;
    } field_char_t;

    field_char_t field_chars[$];

    int mismatch_total = 0;
    int char_total     = 0;
    int request_total  = 0;

    assign fail_count    = mismatch_total;
    assign chars_checked = char_total;
    assign requests_seen = request_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_total++;
    endtask

    function automatic void predict_field(input fmt_request_t r);
        logic [CHAR_W-1:0] rev [0:BUF_LEN-1];
        string             digit_set;
        int                n;
        int                field_w;
        int                digits_w;
        int                base;
        logic [MAG_W-1:0]  mag;
        logic              neg;
        field_char_t       c;
        digit_set = "0123456789abcdef";
        field_w   = (r.width > FIELD_MAX) ? FIELD_MAX : int'(r.width);
        digits_w  = (r.precision > FIELD_MAX) ? FIELD_MAX : int'(r.precision);
        base      = (r.kind == KIND_HEX) ? 16 : 10;
        neg       = (r.kind == KIND_DEC) && r.value[MAG_W-1];
        mag       = neg ? (32'd0 - r.value) : r.value;
        n         = 0;
        do
        begin
            rev[n] = digit_set[int'(mag % base)];
            n      = n + 1;
            mag    = mag / base;
        end
        while (mag != 0 && n < BUF_LEN);
        if (r.has_precision)
        begin
            while (n < digits_w && n < BUF_LEN)
            begin
                rev[n] = "0";
                n      = n + 1;
            end
        end
        if (neg && n < BUF_LEN)
        begin
            rev[n] = "-";
            n      = n + 1;
        end
        while (n < field_w && n < BUF_LEN)
        begin
            rev[n] = " ";
            n      = n + 1;
        end
        for (int k = 0; k < n; k++)
        begin
            c.ch   = rev[n-1-k];
            c.last = (k == n - 1);
            c.len  = FLEN_W'(n);
            field_chars.push_back(c);
        end
    endfunction

    task automatic check_char(input logic [CHAR_W-1:0] ch, input logic last,
                              input logic [FLEN_W-1:0] len);
        field_char_t want;
        char_total++;
        if (field_chars.size() == 0)
        begin
            report_mismatch($sformatf("character 0x%02h arrived with no field pending", ch));
        end
        else
        begin
            want = field_chars.pop_front();
            if (ch !== want.ch)
            begin
                report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", ch, want.ch));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("last %b, expected %b", last, want.last));
            end
            if (len !== want.len)
            begin
                report_mismatch($sformatf("field_length %0d, expected %0d", len, want.len));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chr.valid && chr.ready)
            begin
                check_char(chr.out_char, chr.last, chr.field_length);
            end
            if (req.valid && req.ready)
            begin
                request_total++;
                predict_field('{kind: fmt_kind_t'(req.kind), value: req.value,
                                width: req.width, has_precision: req.has_precision,
                                precision: req.precision});
            end
        end
        pending = field_chars.size();
    end

    initial
    begin
        pending = 0;
    end

endmodule

FILE: dv/int_hex_field_formatter_tb.sv
`timescale 1ns / 1ps

module int_hex_field_formatter_tb;

    import ihf_pkg::*;
    import ihf_tb_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;

    int  fail_count;
    int  pending;
    int  chars_checked;
    int  requests_seen;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  stall_cycles;
    int  directed_count;
    bit  hold_request;

    ihf_req_if req_if ();
    ihf_chr_if chr_if ();

    int_hex_field_formatter u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_if),
        .chr    (chr_if)
    );

    ihf_field_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_if),
        .chr            (chr_if),
        .fail_count     (fail_count),
        .pending        (pending),
        .chars_checked  (chars_checked),
        .requests_seen  (requests_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic fmt_request_t make_request(input fmt_kind_t kind,
                                                  input logic [MAG_W-1:0] value,
                                                  input logic [SIZE_W-1:0] width,
                                                  input logic has_precision,
                                                  input logic [SIZE_W-1:0] precision);
        fmt_request_t r;
        r.kind          = kind;
        r.value         = value;
        r.width         = width;
        r.has_precision = has_precision;
        r.precision     = precision;
        return r;
    endfunction

    function automatic fmt_request_t random_request();
        fmt_request_t      r;
        int                pick;
        logic [MAG_W-1:0]  p10;
        r.kind = fmt_kind_t'($urandom_range(0, 1));
        pick   = $urandom_range(0, 9);
        case (pick)
            0, 1, 2:
            begin
                r.value = $urandom();
            end
            3, 4:
            begin
                r.value = $urandom_range(0, 99);
            end
            5, 6:
            begin
                p10 = 32'd1;
                repeat ($urandom_range(0, 9))
                begin
                    p10 = p10 * 32'd10;
                end
                r.value = p10 - $urandom_range(0, 1);
            end
            7:
            begin
                r.value = 32'd0 - $urandom_range(1, 1000);
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0: r.value = 32'h0000_0000;
                    1: r.value = 32'h7FFF_FFFF;
                    2: r.value = 32'h8000_0000;
                    default: r.value = 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                r.value = $urandom() >> $urandom_range(0, 31);
            end
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            r.width = SIZE_W'($urandom_range(0, 63));
        end
        else
        begin
            r.width = SIZE_W'($urandom_range(0, 16));
        end
        r.has_precision = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
        begin
            r.precision = SIZE_W'($urandom_range(0, 63));
        end
        else
        begin
            r.precision = SIZE_W'($urandom_range(0, 12));
        end
        return r;
    endfunction

    task automatic send_request(input fmt_request_t r);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.kind          <= r.kind;
        req_if.value         <= r.value;
        req_if.width         <= r.width;
        req_if.has_precision <= r.has_precision;
        req_if.precision     <= r.precision;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
    endtask

    task automatic send_random(input int count);
        repeat (count)
        begin
            send_request(random_request());
        end
    endtask

    // The receiver holds ready low for a long stretch whenever a hold-off is requested.
    initial
    begin
        chr_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                chr_if.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                end
                hold_request = 1'b0;
            end
            else
            begin
                chr_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (chr_if.valid && chr_if.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.kind          = KIND_DEC;
        req_if.value         = '0;
        req_if.width         = '0;
        req_if.has_precision = 1'b0;
        req_if.precision     = '0;
        tx_idle_pct          = 9;
        rx_idle_pct          = 9;
        stall_cycles         = 0;
        hold_request         = 1'b0;
        repeat (8)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(KIND_DEC, 32'd0, 6'd0, 1'b0, 6'd0));
        send_request(make_request(KIND_DEC, 32'd0, 6'd0, 1'b1, 6'd0));
        send_request(make_request(KIND_HEX, 32'd0, 6'd0, 1'b1, 6'd0));
        send_request(make_request(KIND_HEX, 32'd0, 6'd5, 1'b1, 6'd3));
        send_request(make_request(KIND_DEC, 32'h7FFF_FFFF, 6'd0, 1'b0, 6'd0));
        send_request(make_request(KIND_DEC, 32'h8000_0000, 6'd0, 1'b0, 6'd0));
        send_request(make_request(KIND_DEC, 32'h8000_0000, 6'd14, 1'b1, 6'd12));
        send_request(make_request(KIND_DEC, 32'hFFFF_FFFF, 6'd0, 1'b0, 6'd0));
        send_request(make_request(KIND_HEX, 32'hFFFF_FFFF, 6'd0, 1'b0, 6'd0));
        send_request(make_request(KIND_HEX, 32'h8000_0000, 6'd9, 1'b0, 6'd0));
        send_request(make_request(KIND_HEX, 32'h0123_4567, 6'd0, 1'b0, 6'd0));
        send_request(make_request(KIND_HEX, 32'h89AB_CDEF, 6'd0, 1'b0, 6'd0));
        send_request(make_request(KIND_HEX, 32'hDEAD_BEEF, 6'd0, 1'b1, 6'd32));
        send_request(make_request(KIND_DEC, 32'd123, 6'd10, 1'b0, 6'd0));
        send_request(make_request(KIND_DEC, 32'd0 - 32'd123, 6'd10, 1'b1, 6'd6));
        send_request(make_request(KIND_DEC, 32'd5, 6'd63, 1'b1, 6'd63));
        send_request(make_request(KIND_DEC, 32'd0 - 32'd5, 6'd0, 1'b1, 6'd63));
        send_request(make_request(KIND_DEC, 32'd0 - 32'd7, 6'd63, 1'b1, 6'd33));
        send_request(make_request(KIND_DEC, 32'd42, 6'd3, 1'b0, 6'd63));
        send_request(make_request(KIND_HEX, 32'h00AB_CDEF, 6'd32, 1'b0, 6'd20));
        send_request(make_request(KIND_DEC, 32'd1000000000, 6'd33, 1'b0, 6'd0));
        send_request(make_request(KIND_DEC, 32'h8000_0001, 6'd11, 1'b1, 6'd11));
        send_request(make_request(KIND_HEX, 32'h0000_00FF, 6'd8, 1'b1, 6'd8));
        send_request(make_request(KIND_DEC, 32'd9, 6'd31, 1'b1, 6'd32));
        directed_count = 24;

        send_random(150);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(100);

        rx_idle_pct  = 9;
        hold_request = 1'b1;
        send_random(100);

        tx_idle_pct = 9;
        send_random(150);

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        $display("%0d requests (%0d directed, the rest random) and %0d characters checked,",
                 requests_seen, directed_count, chars_checked);
        $display("with random idling, an idle-free stretch and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
